// ===== rtl/hfcc_pkg.sv =====
// ----------------------------------------------------------------------------
// hfcc_pkg
// Shared types, constants and the CRC-8 byte update for the humidity frame
// checker and converter.
// ----------------------------------------------------------------------------
package hfcc_pkg;

   // CRC-8, x^8+x^5+x^4+1, MSB first, no final xor
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   localparam logic [16:0] FULL_SCALE  = 17'd65535;
   localparam logic [10:0] TEMP_SPAN   = 11'd1750;
   localparam logic [11:0] TEMP_OFFSET = 12'd450;
   localparam logic [9:0]  HUMI_SPAN   = 10'd1000;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TEMP_CRC = 2'd1;
   localparam logic [1:0] STATUS_HUMI_CRC = 2'd2;

   typedef enum logic [2:0] {
      POS_T_MSB = 3'd0,
      POS_T_LSB = 3'd1,
      POS_T_CRC = 3'd2,
      POS_H_MSB = 3'd3,
      POS_H_LSB = 3'd4,
      POS_H_CRC = 3'd5
   } pos_type;

   // finished frame, before conversion
   typedef struct packed {
      logic [15:0] temp_raw;
      logic [15:0] humi_raw;
      logic [1:0]  status;
   } frame_type;

   // converted result word
   typedef struct packed {
      logic signed [11:0] temperature_tenths;
      logic [9:0]         humidity_tenths;
      logic [1:0]         status;
   } result_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] v;
      v = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

// ===== rtl/hfcc_req_if.sv =====
// ----------------------------------------------------------------------------
// hfcc_req_if
// Valid/ready channel carrying one received frame byte per word.
// ----------------------------------------------------------------------------
interface hfcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// ===== rtl/hfcc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hfcc_rsp_if
// Valid/ready channel carrying one converted measurement per word.
// ----------------------------------------------------------------------------
interface hfcc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [11:0] temperature_tenths;
   logic [9:0]         humidity_tenths;
   logic [1:0]         status;

   modport source (output valid, output temperature_tenths, output humidity_tenths,
                   output status, input ready);
   modport sink   (input valid, input temperature_tenths, input humidity_tenths,
                   input status, output ready);
endinterface

// ===== rtl/hfcc_convert.sv =====
// ----------------------------------------------------------------------------
// hfcc_convert
// Raw 16-bit words to tenths of a unit. Division by 65535 is done as
// y = q0*65536 + lo = q0*65535 + (lo + q0), with one correction step.
// ----------------------------------------------------------------------------
module hfcc_convert (
   input  hfcc_pkg::frame_type  frame,
   output hfcc_pkg::result_type result
);

   logic [26:0]        t_prod;
   logic [10:0]        t_q0;
   logic [16:0]        t_r0;
   logic               t_wrap;
   logic [10:0]        t_q;
   logic [16:0]        t_r;
   logic               t_round;
   logic signed [11:0] t_val;

   logic [25:0]        h_prod;
   logic [9:0]         h_q0;
   logic [16:0]        h_r0;
   logic [9:0]         h_q;

   always_comb begin
      t_prod  = 27'(frame.temp_raw) * 27'(hfcc_pkg::TEMP_SPAN);
      t_q0    = t_prod[26:16];
      t_r0    = {1'b0, t_prod[15:0]} + 17'(t_q0);
      t_wrap  = (t_r0 >= hfcc_pkg::FULL_SCALE);
      t_q     = t_q0 + 11'(t_wrap);
      t_r     = t_wrap ? (t_r0 - hfcc_pkg::FULL_SCALE) : t_r0;
      // negative quotient with a remainder truncates up toward zero
      t_round = (12'(t_q) < hfcc_pkg::TEMP_OFFSET) && (t_r != 17'd0);
      t_val   = $signed(12'(t_q) - hfcc_pkg::TEMP_OFFSET + 12'(t_round));

      h_prod  = 26'(frame.humi_raw) * 26'(hfcc_pkg::HUMI_SPAN);
      h_q0    = h_prod[25:16];
      h_r0    = {1'b0, h_prod[15:0]} + 17'(h_q0);
      h_q     = h_q0 + 10'(h_r0 >= hfcc_pkg::FULL_SCALE);

      result.status = frame.status;
      if (frame.status == hfcc_pkg::STATUS_OK) begin
         result.temperature_tenths = t_val;
         result.humidity_tenths    = h_q;
      end else begin
         result.temperature_tenths = '0;
         result.humidity_tenths    = '0;
      end
   end

endmodule

// ===== rtl/humidity_frame_check_convert_core.sv =====
// ----------------------------------------------------------------------------
// humidity_frame_check_convert_core
// Checks the two CRC-8 protected words of a six-byte sensor frame and
// converts them to tenths of a degree and tenths of a percent.
//
//   channel  dir  handshake     payload
//   req_ch   in   valid/ready   data_byte[7:0], frame_start
//   rsp_ch   out  valid/ready   temperature_tenths[11:0] s, humidity_tenths[9:0],
//                               status[1:0]
//
// One byte per cycle while req_ch.ready is high; the sixth byte is registered into
// the frame register, then converted into the output register.
// Synchronous active-high reset clears byte position, CRC and valid flags.
// A stalled output holds the frame register, and req_ch.ready drops only
// when both the frame register and the output register are full.
// ----------------------------------------------------------------------------
module humidity_frame_check_convert_core (
   input  logic         clock,
   input  logic         reset,
   hfcc_req_if.sink     req_ch,
   hfcc_rsp_if.source   rsp_ch
);

   hfcc_pkg::pos_type    pos_ff, pos_in, pos_cur;
   logic [7:0]           crc_ff, crc_in, crc_cur;
   logic [15:0]          temp_raw_ff, temp_raw_in;
   logic [15:0]          humi_raw_ff, humi_raw_in;
   logic                 temp_bad_ff, temp_bad_in;

   hfcc_pkg::frame_type  frame_ff, frame_in;
   logic                 frame_valid_ff, frame_valid_in;
   hfcc_pkg::result_type result_ff, result_conv;
   logic                 result_valid_ff, result_valid_in;

   logic                 req_take;
   logic                 frame_done;
   logic                 out_free;
   logic                 frame_free;
   logic                 humi_bad;

   assign out_free     = !result_valid_ff || rsp_ch.ready;
   assign frame_free   = !frame_valid_ff || out_free;
   assign req_ch.ready = frame_free;
   assign req_take     = req_ch.valid && frame_free;

   // a start byte or an impossible position restarts the frame
   always_comb begin
      if (req_ch.frame_start || (3'(pos_ff) > 3'(hfcc_pkg::POS_H_CRC))) begin
         pos_cur = hfcc_pkg::POS_T_MSB;
         crc_cur = hfcc_pkg::CRC_INIT;
      end else begin
         pos_cur = pos_ff;
         crc_cur = crc_ff;
      end
   end

   // next position
   always_comb begin
      pos_in = pos_ff;
      if (req_take) begin
         if (pos_cur == hfcc_pkg::POS_H_CRC) begin
            pos_in = hfcc_pkg::POS_T_MSB;
         end else begin
            pos_in = hfcc_pkg::pos_type'(3'(pos_cur) + 3'd1);
         end
      end
   end

   // per-position datapath
   always_comb begin
      crc_in      = crc_ff;
      temp_raw_in = temp_raw_ff;
      humi_raw_in = humi_raw_ff;
      temp_bad_in = temp_bad_ff;
      frame_done  = 1'b0;
      humi_bad    = (crc_cur != req_ch.data_byte);
      if (req_take) begin
         unique case (pos_cur)
            hfcc_pkg::POS_T_MSB: begin
               temp_raw_in = {req_ch.data_byte, 8'h00};
               crc_in      = hfcc_pkg::crc8_byte(crc_cur, req_ch.data_byte);
            end
            hfcc_pkg::POS_T_LSB: begin
               temp_raw_in = {temp_raw_ff[15:8], req_ch.data_byte};
               crc_in      = hfcc_pkg::crc8_byte(crc_cur, req_ch.data_byte);
            end
            hfcc_pkg::POS_T_CRC: begin
               temp_bad_in = (crc_cur != req_ch.data_byte);
               crc_in      = hfcc_pkg::CRC_INIT;
            end
            hfcc_pkg::POS_H_MSB: begin
               humi_raw_in = {req_ch.data_byte, 8'h00};
               crc_in      = hfcc_pkg::crc8_byte(crc_cur, req_ch.data_byte);
            end
            hfcc_pkg::POS_H_LSB: begin
               humi_raw_in = {humi_raw_ff[15:8], req_ch.data_byte};
               crc_in      = hfcc_pkg::crc8_byte(crc_cur, req_ch.data_byte);
            end
            default: begin
               frame_done = 1'b1;
               crc_in     = hfcc_pkg::CRC_INIT;
            end
         endcase
      end
   end

   always_comb begin
      frame_in.temp_raw = temp_raw_ff;
      frame_in.humi_raw = humi_raw_ff;
      priority if (temp_bad_ff) begin
         frame_in.status = hfcc_pkg::STATUS_TEMP_CRC;
      end else if (humi_bad) begin
         frame_in.status = hfcc_pkg::STATUS_HUMI_CRC;
      end else begin
         frame_in.status = hfcc_pkg::STATUS_OK;
      end
   end

   always_comb begin
      frame_valid_in = frame_valid_ff;
      if (frame_done) begin
         frame_valid_in = 1'b1;
      end else if (out_free) begin
         frame_valid_in = 1'b0;
      end
      result_valid_in = result_valid_ff;
      if (out_free) begin
         result_valid_in = frame_valid_ff;
      end
   end

   hfcc_convert u_convert (
      .frame  (frame_ff),
      .result (result_conv)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= hfcc_pkg::POS_T_MSB;
         crc_ff          <= hfcc_pkg::CRC_INIT;
         frame_valid_ff  <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         pos_ff          <= pos_in;
         crc_ff          <= crc_in;
         frame_valid_ff  <= frame_valid_in;
         result_valid_ff <= result_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_raw_ff <= temp_raw_in;
      humi_raw_ff <= humi_raw_in;
      temp_bad_ff <= temp_bad_in;
      if (frame_done) begin
         frame_ff <= frame_in;
      end
      if (out_free && frame_valid_ff) begin
         result_ff <= result_conv;
      end
   end

   assign rsp_ch.valid              = result_valid_ff;
   assign rsp_ch.temperature_tenths = result_ff.temperature_tenths;
   assign rsp_ch.humidity_tenths    = result_ff.humidity_tenths;
   assign rsp_ch.status             = result_ff.status;

   // bad CRC words carry zeroed readings
   assert property (@(posedge clock) disable iff (reset)
      result_valid_ff && (result_ff.status != hfcc_pkg::STATUS_OK) |->
         (result_ff.temperature_tenths == 12'sd0) && (result_ff.humidity_tenths == 10'd0))
      else $error("nonzero reading with bad CRC status");

   assert property (@(posedge clock) disable iff (reset)
      result_valid_ff |->
         (result_ff.temperature_tenths >= -12'sd450) &&
         (result_ff.temperature_tenths <= 12'sd1300) &&
         (result_ff.humidity_tenths <= 10'd1000))
      else $error("converted reading out of range");

   // a waiting frame is neither dropped nor overwritten
   assert property (@(posedge clock) disable iff (reset)
      frame_valid_ff && !out_free |=> frame_valid_ff && $stable(frame_ff))
      else $error("frame register lost while output stalled");

   assert property (@(posedge clock) disable iff (reset)
      frame_done |-> frame_free)
      else $error("frame completed with frame register busy");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Sends sensor frame bytes into humidity_frame_check_convert_core and checks
// each converted measurement against a predictor kept alongside the stimulus.
// Covers scale end points, CRC faults, frame restarts, broken frames and noise,
// under random idling on both channels and one stretch at full rate.
// ----------------------------------------------------------------------------
module testbench;

   logic clock;
   logic reset;

   hfcc_req_if req_ch ();
   hfcc_rsp_if rsp_ch ();

   humidity_frame_check_convert_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // predictor state
   hfcc_pkg::pos_type    frame_pos     = hfcc_pkg::POS_T_MSB;
   logic [7:0]           word_crc      = hfcc_pkg::CRC_INIT;
   logic [15:0]          temp_word     = '0;
   logic [15:0]          humi_word     = '0;
   logic                 temp_word_bad = 1'b0;
   hfcc_pkg::result_type readings_due[$];

   int  bytes_taken   = 0;
   int  readings_seen = 0;
   int  crc_faults    = 0;
   int  mismatches    = 0;
   logic full_rate    = 1'b0;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [8:0] acc;
      acc = {1'b0, crc ^ data};
      for (int i = 0; i < 8; i++) begin
         acc = acc << 1;
         if (acc[8]) begin
            acc = acc ^ 9'h131;
         end
      end
      return acc[7:0];
   endfunction

   function automatic logic [15:0] pick_raw();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // advance the frame state by one byte; a sixth byte yields one reading
   task automatic track_frame_byte(input logic [7:0] data, input logic start);
      logic                 humi_bad;
      logic [1:0]           status;
      longint               t_val;
      longint               h_val;
      hfcc_pkg::result_type reading;
      if (start) begin
         frame_pos = hfcc_pkg::POS_T_MSB;
         word_crc  = hfcc_pkg::CRC_INIT;
      end
      case (frame_pos)
         hfcc_pkg::POS_T_MSB: begin
            temp_word = {data, 8'h00};
            word_crc  = crc8_step(word_crc, data);
            frame_pos = hfcc_pkg::POS_T_LSB;
         end
         hfcc_pkg::POS_T_LSB: begin
            temp_word[7:0] = data;
            word_crc       = crc8_step(word_crc, data);
            frame_pos      = hfcc_pkg::POS_T_CRC;
         end
         hfcc_pkg::POS_T_CRC: begin
            temp_word_bad = (word_crc != data);
            word_crc      = hfcc_pkg::CRC_INIT;
            frame_pos     = hfcc_pkg::POS_H_MSB;
         end
         hfcc_pkg::POS_H_MSB: begin
            humi_word = {data, 8'h00};
            word_crc  = crc8_step(word_crc, data);
            frame_pos = hfcc_pkg::POS_H_LSB;
         end
         hfcc_pkg::POS_H_LSB: begin
            humi_word[7:0] = data;
            word_crc       = crc8_step(word_crc, data);
            frame_pos      = hfcc_pkg::POS_H_CRC;
         end
         default: begin
            humi_bad = (word_crc != data);
            status   = temp_word_bad ? hfcc_pkg::STATUS_TEMP_CRC :
                       (humi_bad ? hfcc_pkg::STATUS_HUMI_CRC : hfcc_pkg::STATUS_OK);
            t_val    = 0;
            h_val    = 0;
            if (status == hfcc_pkg::STATUS_OK) begin
               // signed division truncates toward zero
               t_val = (longint'(temp_word) * longint'(hfcc_pkg::TEMP_SPAN)
                        - longint'(hfcc_pkg::TEMP_OFFSET) * longint'(hfcc_pkg::FULL_SCALE))
                       / longint'(hfcc_pkg::FULL_SCALE);
               h_val = (longint'(humi_word) * longint'(hfcc_pkg::HUMI_SPAN))
                       / longint'(hfcc_pkg::FULL_SCALE);
            end
            reading.temperature_tenths = t_val[11:0];
            reading.humidity_tenths    = h_val[9:0];
            reading.status             = status;
            readings_due.push_back(reading);
            word_crc  = hfcc_pkg::CRC_INIT;
            frame_pos = hfcc_pkg::POS_T_MSB;
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] data, input logic start);
      if (!full_rate) begin
         while ($urandom_range(99) < 28) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid       <= 1'b1;
      req_ch.data_byte   <= data;
      req_ch.frame_start <= start;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      track_frame_byte(data, start);
      bytes_taken++;
   endtask

   // send the first nbytes of a frame, optionally with either CRC byte corrupted
   task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                             input bit t_ok, input bit h_ok, input bit with_start,
                             input int nbytes);
      logic [7:0] frame[6];
      logic [7:0] crc_t;
      logic [7:0] crc_h;
      crc_t = crc8_step(crc8_step(hfcc_pkg::CRC_INIT, t_raw[15:8]), t_raw[7:0]);
      crc_h = crc8_step(crc8_step(hfcc_pkg::CRC_INIT, h_raw[15:8]), h_raw[7:0]);
      if (!t_ok) begin
         crc_t = crc_t ^ 8'($urandom_range(1, 255));
      end
      if (!h_ok) begin
         crc_h = crc_h ^ 8'($urandom_range(1, 255));
      end
      frame = '{t_raw[15:8], t_raw[7:0], crc_t, h_raw[15:8], h_raw[7:0], crc_h};
      for (int i = 0; i < nbytes; i++) begin
         send_byte(frame[i], with_start && (i == 0));
      end
   endtask

   task automatic wait_for_readings();
      req_ch.valid <= 1'b0;
      while (readings_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // mostly good frames, some truncated, some loose noise bytes
   task automatic run_traffic(input int n_bytes);
      int target;
      int pick;
      int count;
      target = bytes_taken + n_bytes;
      while (bytes_taken < target) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_frame(pick_raw(), pick_raw(), $urandom_range(99) < 85,
                       $urandom_range(99) < 85, $urandom_range(3) != 0, 6);
         end else if (pick < 85) begin
            send_frame(pick_raw(), pick_raw(), 1'b1, 1'b1, 1'($urandom_range(1)),
                       $urandom_range(1, 5));
         end else begin
            count = $urandom_range(1, 8);
            repeat (count) send_byte(8'($urandom), $urandom_range(3) == 0);
         end
      end
   endtask

   task automatic test_scale_extremes();
      send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1, 6);
      // no start flag: count wraps into the next frame
      send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b0, 6);
   endtask

   task automatic test_crc_errors();
      // both words bad: temperature fault wins
      send_frame(16'h6666, 16'h8000, 1'b0, 1'b0, 1'b1, 6);
   endtask

   task automatic test_restart_mid_frame();
      send_frame(16'h1234, 16'h5678, 1'b1, 1'b1, 1'b1, 2);
      send_frame(16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b1, 6);
   endtask

   task automatic test_random_traffic(input int n_bytes);
      run_traffic(n_bytes);
   endtask

   task automatic test_drain_pause();
      run_traffic(200);
      wait_for_readings();
      run_traffic(200);
   endtask

   task automatic test_full_rate();
      full_rate <= 1'b1;
      run_traffic(240);
      full_rate <= 1'b0;
   endtask

   // result side: random stalls, every accepted word checked in order
   always @(posedge clock) begin
      hfcc_pkg::result_type due;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (readings_due.size() == 0) begin
            $display("%0t unexpected result: temp %0d humi %0d status %0d", $time,
                     rsp_ch.temperature_tenths, rsp_ch.humidity_tenths, rsp_ch.status);
            mismatches++;
         end else begin
            due = readings_due.pop_front();
            readings_seen++;
            if (due.status != hfcc_pkg::STATUS_OK) begin
               crc_faults++;
            end
            if (rsp_ch.temperature_tenths !== due.temperature_tenths) begin
               $display("%0t temperature_tenths: expected %0d, actual %0d", $time,
                        due.temperature_tenths, rsp_ch.temperature_tenths);
               mismatches++;
            end
            if (rsp_ch.humidity_tenths !== due.humidity_tenths) begin
               $display("%0t humidity_tenths: expected %0d, actual %0d", $time,
                        due.humidity_tenths, rsp_ch.humidity_tenths);
               mismatches++;
            end
            if (rsp_ch.status !== due.status) begin
               $display("%0t status: expected %0d, actual %0d", $time,
                        due.status, rsp_ch.status);
               mismatches++;
            end
         end
      end
      rsp_ch.ready <= full_rate || ($urandom_range(99) >= 28);
   end

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.data_byte   <= 8'h00;
      req_ch.frame_start <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_scale_extremes();
      test_crc_errors();
      test_restart_mid_frame();
      test_random_traffic(600);
      test_drain_pause();
      test_full_rate();
      test_random_traffic(250);

      wait_for_readings();
      repeat (20) @(posedge clock);
      if (readings_due.size() != 0) begin
         $display("%0t %0d expected results never arrived", $time, readings_due.size());
         mismatches++;
      end
      $display("sent %0d frame bytes, checked %0d measurements (%0d with CRC faults)",
               bytes_taken, readings_seen, crc_faults);
      $display("covered scale end points, restarts, truncated frames, noise and stalls");
      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t timeout", $time);
      $display("testbench NOT OK");
      $finish;
   end

endmodule
